FILE: src/shcd_pkg.sv
// Package: types, codes and the CRC byte update shared by the deframer modules.
package shcd_pkg;

  localparam int HEADER_BYTES = 7;
  localparam int MAX_PAYLOAD  = 256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [1:0] OP_BYTE     = 2'd0;
  localparam logic [1:0] OP_FLUSH    = 2'd1;
  localparam logic [1:0] OP_OVERFLOW = 2'd2;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_VERSION     = 2'd2;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd3;

  localparam logic [3:0] EV_HUNT        = 4'd0;
  localparam logic [3:0] EV_SYNC        = 4'd1;
  localparam logic [3:0] EV_HEADER      = 4'd2;
  localparam logic [3:0] EV_PAYLOAD     = 4'd3;
  localparam logic [3:0] EV_CRC         = 4'd4;
  localparam logic [3:0] EV_OK          = 4'd5;
  localparam logic [3:0] EV_BAD_VERSION = 4'd6;
  localparam logic [3:0] EV_BAD_LENGTH  = 4'd7;
  localparam logic [3:0] EV_BAD_CRC     = 4'd8;

  typedef enum logic [5:0] {
    PH_SYNC0   = 6'b000001,
    PH_SYNC1   = 6'b000010,
    PH_HEADER  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRC0    = 6'b010000,
    PH_CRC1    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  protocol_version;
    logic [15:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic        overflow_flag;
    logic [7:0]  data_byte;
    logic [15:0] payload_index;
    logic [7:0]  packet_type;
    logic [15:0] sequence_number;
    logic [15:0] payload_length;
    logic [7:0]  header_flags;
    logic [15:0] error_detail;
    logic [31:0] packet_count;
    logic [31:0] error_count;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/sync_header_crc_deframer.sv
// Top level: input register, parser, result register and configuration port.
// A word accepted into the input register is parsed and then held in the result register, which drives out_valid.
// Throughput: one word per cycle; the input register and the result register advance
// together whenever the result register is empty or being read.
// Reset (rst, synchronous): parser hunts for the first sync byte, CRC preset, counters
// cleared, configuration back to its defaults, both register stages empty.
module sync_header_crc_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_res,
  output logic        overflow_flag,
  output logic [7:0]  data_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  packet_type,
  output logic [15:0] sequence_number,
  output logic [15:0] payload_length,
  output logic [7:0]  header_flags,
  output logic [15:0] error_detail,
  output logic [31:0] packet_count,
  output logic [31:0] error_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import shcd_pkg::*;

  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_byte;
  logic       advance, fire;
  cfg_t       cfg;
  result_t    res, out_res;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign fire      = s1_valid && advance;

  shcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  shcd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .op   (s1_op),
    .rx   (s1_byte),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= operation;
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign event_res       = out_res.event_res;
  assign overflow_flag   = out_res.overflow_flag;
  assign data_byte       = out_res.data_byte;
  assign payload_index   = out_res.payload_index;
  assign packet_type     = out_res.packet_type;
  assign sequence_number = out_res.sequence_number;
  assign payload_length  = out_res.payload_length;
  assign header_flags    = out_res.header_flags;
  assign error_detail    = out_res.error_detail;
  assign packet_count    = out_res.packet_count;
  assign error_count     = out_res.error_count;

endmodule

FILE: src/shcd_cfg_regs.sv
// Configuration register file: sync bytes, protocol version and length limit.
module shcd_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output shcd_pkg::cfg_t     cfg
);
  import shcd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first       <= 8'd170;
      cfg.sync_second      <= 8'd85;
      cfg.protocol_version <= 8'd1;
      cfg.max_payload_len  <= 16'(MAX_PAYLOAD);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  cfg.sync_first       <= cfg_data[7:0];
        CFG_SYNC_SECOND: cfg.sync_second      <= cfg_data[7:0];
        CFG_VERSION:     cfg.protocol_version <= cfg_data[7:0];
        CFG_MAX_LEN:     cfg.max_payload_len  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/shcd_parser.sv
// Parser: sync hunt, header capture, payload forwarding, CRC check and counters.
module shcd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [1:0]          op,
  input  logic [7:0]          rx,
  input  shcd_pkg::cfg_t      cfg,
  output shcd_pkg::result_t   res
);
  import shcd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  header_store [HEADER_BYTES];
  logic [2:0]  header_position, header_position_next;
  logic [15:0] payload_position, payload_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [31:0] valid_packets, valid_packets_next;
  logic [31:0] error_total, error_total_next;
  logic        hdr_write, show_hdr, flush;
  logic [15:0] crc_upd, hdr_len, pos_inc;

  assign crc_upd = crc_byte(running_crc, rx);
  assign hdr_len = {header_store[5], header_store[4]};
  assign pos_inc = payload_position + 16'd1;

  always_comb begin
    phase_next            = phase;
    header_position_next  = header_position;
    payload_position_next = payload_position;
    running_crc_next      = running_crc;
    crc_low_byte_next     = crc_low_byte;
    valid_packets_next    = valid_packets;
    error_total_next      = error_total;
    hdr_write             = 1'b0;
    show_hdr              = 1'b0;
    flush                 = 1'b0;
    res                   = '0;
    case (op)
      OP_BYTE: begin
        res.data_byte = rx;
        case (phase)
          PH_SYNC0: begin
            if (rx == cfg.sync_first) begin
              res.event_res = EV_SYNC;
              phase_next    = PH_SYNC1;
            end
          end
          PH_SYNC1: begin
            if (rx == cfg.sync_second) begin
              res.event_res        = EV_SYNC;
              header_position_next = 3'd0;
              running_crc_next     = CRC_INIT;
              phase_next           = PH_HEADER;
            end else if (rx == cfg.sync_first) begin
              res.event_res = EV_SYNC;
            end else begin
              phase_next = PH_SYNC0;
            end
          end
          PH_HEADER: begin
            hdr_write            = 1'b1;
            running_crc_next     = crc_upd;
            header_position_next = header_position + 3'd1;
            res.event_res        = EV_HEADER;
            if (header_position == 3'(HEADER_BYTES - 1)) begin
              if (header_store[0] != cfg.protocol_version) begin
                res.event_res    = EV_BAD_VERSION;
                res.error_detail = {8'h00, header_store[0]};
                error_total_next = error_total + 32'd1;
                flush            = 1'b1;
              end else if (hdr_len > cfg.max_payload_len) begin
                res.event_res    = EV_BAD_LENGTH;
                res.error_detail = hdr_len;
                show_hdr         = 1'b1;
                error_total_next = error_total + 32'd1;
                flush            = 1'b1;
              end else begin
                show_hdr              = 1'b1;
                payload_position_next = 16'd0;
                phase_next            = (hdr_len == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            res.event_res         = EV_PAYLOAD;
            show_hdr              = 1'b1;
            res.payload_index     = payload_position;
            running_crc_next      = crc_upd;
            payload_position_next = pos_inc;
            if (pos_inc >= hdr_len || pos_inc == 16'd0) begin
              phase_next = PH_CRC0;
            end
          end
          PH_CRC0: begin
            res.event_res     = EV_CRC;
            show_hdr          = 1'b1;
            crc_low_byte_next = rx;
            phase_next        = PH_CRC1;
          end
          PH_CRC1: begin
            show_hdr = 1'b1;
            if ({rx, crc_low_byte} == running_crc) begin
              res.event_res      = EV_OK;
              valid_packets_next = valid_packets + 32'd1;
            end else begin
              res.event_res    = EV_BAD_CRC;
              res.error_detail = {8'h00, header_store[1]};
              error_total_next = error_total + 32'd1;
            end
            flush = 1'b1;
          end
          default: flush = 1'b1;
        endcase
      end
      OP_FLUSH: flush = 1'b1;
      OP_OVERFLOW: begin
        flush             = 1'b1;
        error_total_next  = error_total + 32'd1;
        res.event_res     = EV_BAD_CRC;
        res.overflow_flag = 1'b1;
      end
      default: ;
    endcase
    if (flush) begin
      phase_next            = PH_SYNC0;
      header_position_next  = 3'd0;
      payload_position_next = 16'd0;
      running_crc_next      = CRC_INIT;
      crc_low_byte_next     = 8'd0;
    end
    if (show_hdr) begin
      res.packet_type     = header_store[1];
      res.sequence_number = {header_store[3], header_store[2]};
      res.payload_length  = hdr_len;
      res.header_flags    = (phase == PH_HEADER) ? rx : header_store[6];
    end
    res.packet_count = valid_packets_next;
    res.error_count  = error_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SYNC0;
      header_position  <= 3'd0;
      payload_position <= 16'd0;
      running_crc      <= CRC_INIT;
      crc_low_byte     <= 8'd0;
      valid_packets    <= 32'd0;
      error_total      <= 32'd0;
    end else if (fire) begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      payload_position <= payload_position_next;
      running_crc      <= running_crc_next;
      crc_low_byte     <= crc_low_byte_next;
      valid_packets    <= valid_packets_next;
      error_total      <= error_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hdr_write) begin
      header_store[header_position] <= rx;
    end
  end

  a_crc_close: assert property (@(posedge clk) disable iff (rst)
    fire && op == OP_BYTE && phase == PH_CRC1 |=> phase == PH_SYNC0 && running_crc == CRC_INIT)
    else $error("parser not flushed after closing CRC byte");

  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    fire && op == OP_OVERFLOW |=> error_total == $past(error_total) + 32'd1)
    else $error("overflow did not count an error");

  a_idle_counts: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(valid_packets) && $stable(error_total))
    else $error("counter moved without a word");

  a_hdr_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> header_position < 3'(HEADER_BYTES))
    else $error("header position past header length");

endmodule
